// ===== rtl/core/swh_pkg.sv =====
// Package for the string word hash block: types, constants and the mixing
// functions shared by the mixing and finishing stages.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swh_pkg;

  // Default width of the byte-length field.
  localparam int LenWidthDefault = 16;

  // Word and counter widths.
  localparam int WordWidth  = 32;
  localparam int CountWidth = 14;
  localparam int RawLenWidth = CountWidth + 2;
  localparam logic [CountWidth-1:0] CountMax = '1;

  // Shift amounts used by the full-word round and the tail rules.
  localparam int ShRoundHi   = 11;
  localparam int ShRoundMix  = 16;
  localparam int ShRoundAdd  = 11;
  localparam int ShTail3Byte = 18;
  localparam int ShTail2Xor  = 11;
  localparam int ShTail2Add  = 17;
  localparam int ShTail1Xor  = 10;

  // How a word is handled, from the position of its first zero byte.
  typedef enum logic [2:0] {
    TAIL_NONE  = 3'd0,
    TAIL_ONE   = 3'd1,
    TAIL_TWO   = 3'd2,
    TAIL_THREE = 3'd3,
    TAIL_FULL  = 3'd4
  } tail_kind_t;

  // Terminated string on its way from the mixing stage to the finishing stage.
  typedef struct packed {
    logic                   valid;
    logic [WordWidth-1:0]   hash_pre;
    logic [RawLenWidth-1:0] len_raw;
  } swh_mid_t;

  // Classify a word by the index of its first zero byte.
  function automatic tail_kind_t tail_kind(input logic [WordWidth-1:0] w);
    tail_kind_t k;
    if (w[7:0] == 8'h00) begin
      k = TAIL_NONE;
    end else if (w[15:8] == 8'h00) begin
      k = TAIL_ONE;
    end else if (w[23:16] == 8'h00) begin
      k = TAIL_TWO;
    end else if (w[31:24] == 8'h00) begin
      k = TAIL_THREE;
    end else begin
      k = TAIL_FULL;
    end
    return k;
  endfunction

  // Sign-extend one byte to a full word.
  function automatic logic [WordWidth-1:0] sext8(input logic [7:0] b);
    return {{(WordWidth-8){b[7]}}, b};
  endfunction

  // One mixing round over both 16-bit halves of a word.
  function automatic logic [WordWidth-1:0] mix_round(input logic [WordWidth-1:0] h_in,
                                                     input logic [WordWidth-1:0] w);
    logic [WordWidth-1:0] h;
    logic [WordWidth-1:0] t;
    h = h_in + {16'h0000, w[15:0]};
    t = ({16'h0000, w[31:16]} << ShRoundHi) ^ h;
    h = (h << ShRoundMix) ^ t;
    h = h + (h >> ShRoundAdd);
    return h;
  endfunction

  // Tail rules for the zero to three bytes before the terminator.
  function automatic logic [WordWidth-1:0] mix_tail(input logic [WordWidth-1:0] h_in,
                                                    input logic [WordWidth-1:0] w,
                                                    input tail_kind_t k);
    logic [WordWidth-1:0] h;
    h = h_in;
    case (k)
      TAIL_THREE: begin
        h = h + {16'h0000, w[15:0]};
        h = h ^ (h << 16);
        h = h ^ (sext8(w[23:16]) << ShTail3Byte);
        h = h + (h >> 11);
      end
      TAIL_TWO: begin
        h = h + {16'h0000, w[15:0]};
        h = h ^ (h << ShTail2Xor);
        h = h + (h >> ShTail2Add);
      end
      TAIL_ONE: begin
        h = h + sext8(w[7:0]);
        h = h ^ (h << ShTail1Xor);
        h = h + (h >> 1);
      end
      default: begin
        h = h_in;
      end
    endcase
    return h;
  endfunction

  // Final six-step avalanche.
  function automatic logic [WordWidth-1:0] avalanche(input logic [WordWidth-1:0] h_in);
    logic [WordWidth-1:0] h;
    h = h_in;
    h = h ^ (h << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    h = h + (h >> 17);
    h = h ^ (h << 25);
    h = h + (h >> 6);
    return h;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/swh_if.sv =====
// Valid/ready channel interfaces for the string word hash block.
// Depends on swh_pkg for the word width.
`timescale 1ns / 1ps
`default_nettype none

// Channel that carries one string word.
interface swh_word_if;
  logic                          valid;
  logic                          ready;
  logic [swh_pkg::WordWidth-1:0] word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

// Channel that carries one finished hash and its byte length.
interface swh_result_if #(
  parameter int LEN_WIDTH = swh_pkg::LenWidthDefault
);
  logic                          valid;
  logic                          ready;
  logic [swh_pkg::WordWidth-1:0] hash_value;
  logic [LEN_WIDTH-1:0]          length_bytes;

  modport source (output valid, output hash_value, output length_bytes, input ready);
  modport sink (input valid, input hash_value, input length_bytes, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/swh_mix.sv =====
// Mixing stage: runs the per-word round or the tail rules against the running
// hash and word count, and hands terminated strings on. Depends on swh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swh_mix (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [swh_pkg::WordWidth-1:0] in_word,
  output logic                          in_take,
  output swh_pkg::swh_mid_t             mid,
  input  logic                          mid_take
);
  import swh_pkg::*;

  logic [WordWidth-1:0]   hash_acc;
  logic [CountWidth-1:0]  word_count;
  logic                   mid_valid;
  logic [WordWidth-1:0]   mid_hash;
  logic [RawLenWidth-1:0] mid_len;

  tail_kind_t             kind;
  logic                   is_full;
  logic                   mid_free;
  logic [WordWidth-1:0]   round_hash;
  logic [WordWidth-1:0]   tail_hash;

  // Classify the word and compute both candidate hashes.
  always_comb begin
    kind       = tail_kind(in_word);
    is_full    = (kind == TAIL_FULL);
    round_hash = mix_round(hash_acc, in_word);
    tail_hash  = mix_tail(hash_acc, in_word, kind);
  end

  // A full word only touches the state; a terminating word needs a free slot.
  assign mid_free = !mid_valid || mid_take;
  assign in_take  = in_valid && (is_full || mid_free);

  // Running hash and word counter; cleared once a string ends.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_acc   <= '0;
      word_count <= '0;
    end else if (in_take) begin
      if (is_full) begin
        hash_acc <= round_hash;
        if (word_count != CountMax) begin
          word_count <= word_count + 1'b1;
        end
      end else begin
        hash_acc   <= '0;
        word_count <= '0;
      end
    end
  end

  // Hand-off register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (mid_free) begin
      mid_valid <= in_valid && !is_full;
    end
  end

  // Hand-off register payload: pre-avalanche hash and raw length.
  always_ff @(posedge clk) begin
    if (in_take && !is_full) begin
      mid_hash <= tail_hash;
      mid_len  <= {word_count, kind[1:0]};
    end
  end

  assign mid.valid    = mid_valid;
  assign mid.hash_pre = mid_hash;
  assign mid.len_raw  = mid_len;

endmodule

`default_nettype wire

// ===== rtl/core/swh_final.sv =====
// Finishing stage: avalanches the hash, clamps the length to the port width
// and holds the result word until it is taken. Depends on swh_pkg and swh_if.
`timescale 1ns / 1ps
`default_nettype none

module swh_final #(
  parameter int LEN_WIDTH = swh_pkg::LenWidthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  swh_pkg::swh_mid_t mid,
  output logic              mid_take,
  swh_result_if.source      results
);
  import swh_pkg::*;

  localparam int CalcWidth = (LEN_WIDTH > RawLenWidth) ? LEN_WIDTH : RawLenWidth;

  logic                 out_valid;
  logic [WordWidth-1:0] out_hash;
  logic [LEN_WIDTH-1:0] out_len;
  logic                 out_free;
  logic [CalcWidth-1:0] len_ext;
  logic [CalcWidth-1:0] len_max;
  logic [CalcWidth-1:0] len_sat;

  // Clamp the length to what the port can hold.
  always_comb begin
    len_ext = CalcWidth'(mid.len_raw);
    len_max = CalcWidth'({LEN_WIDTH{1'b1}});
    len_sat = (len_ext > len_max) ? len_max : len_ext;
  end

  assign out_free = !out_valid || results.ready;
  assign mid_take = mid.valid && out_free;

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= mid.valid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (mid_take) begin
      out_hash <= avalanche(mid.hash_pre);
      out_len  <= len_sat[LEN_WIDTH-1:0];
    end
  end

  assign results.valid        = out_valid;
  assign results.hash_value   = out_hash;
  assign results.length_bytes = out_len;

endmodule

`default_nettype wire

// ===== rtl/core/string_word_hash.sv =====
// Top level of the string word hash block: input register, mixing stage and
// finishing stage. Depends on swh_pkg, swh_if, swh_mix and swh_final.
//
//   Channel   Direction  Word carries
//   words     in         word: four string bytes, first byte in bits 7:0
//   results   out        hash_value, length_bytes of one finished string
//
// One word is taken every cycle unless a terminating word waits for a slot. A
// word with no zero byte updates the running hash and produces nothing; the
// terminating word's result passes through the input register, the mixing
// register and the output register. A stalled results channel backs up only
// through the registers that hold finished strings; full words keep flowing
// until one of those slots is needed. Reset is synchronous and clears the
// running hash, the word count and all valid bits.
`timescale 1ns / 1ps
`default_nettype none

module string_word_hash #(
  parameter int LEN_WIDTH = swh_pkg::LenWidthDefault
) (
  input  logic         clk,
  input  logic         rst,
  swh_word_if.sink     words,
  swh_result_if.source results
);
  import swh_pkg::*;

  logic                 in_valid;
  logic [WordWidth-1:0] in_word;
  logic                 in_take;
  swh_mid_t             mid;
  logic                 mid_take;

  assign words.ready = !in_valid || in_take;

  // Input register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (words.ready) begin
      in_valid <= words.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (words.valid && words.ready) begin
      in_word <= words.word;
    end
  end

  swh_mix u_mix (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_word  (in_word),
    .in_take  (in_take),
    .mid      (mid),
    .mid_take (mid_take)
  );

  swh_final #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_final (
    .clk      (clk),
    .rst      (rst),
    .mid      (mid),
    .mid_take (mid_take),
    .results  (results)
  );

endmodule

`default_nettype wire
